>>> rtl/vda_pkg.sv
// ----------------------------------------------------------------------------
// vda_pkg
// Shared types, constants and step functions of the deflection angle pipeline.
// ----------------------------------------------------------------------------
package vda_pkg;

    localparam int DIMENSIONS      = 3;
    localparam int COORD_FRAC_BITS = 16;
    // tolerance 2^-20 on |a||b| compared against the raw squared lengths
    localparam int TOL_SHIFT       = 4 * COORD_FRAC_BITS - 40;

    localparam int SQRT_STEPS   = 31;
    localparam int DIV_STEPS    = 31;
    localparam int CORDIC_STEPS = 20;

    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_ORIGIN_X   = 3'd0;
    localparam t_reg_idx REG_ORIGIN_Y   = 3'd1;
    localparam t_reg_idx REG_ORIGIN_Z   = 3'd2;
    localparam t_reg_idx REG_USE_AXIS   = 3'd3;
    localparam t_reg_idx REG_AXIS_X     = 3'd4;
    localparam t_reg_idx REG_AXIS_Y     = 3'd5;
    localparam t_reg_idx REG_AXIS_Z     = 3'd6;
    localparam t_reg_idx REG_DISP_COUNT = 3'd7;

    typedef logic signed [33:0] t_v1;
    typedef logic signed [49:0] t_pr1;
    typedef logic signed [51:0] t_sum1;
    typedef logic signed [37:0] t_pj;
    typedef logic signed [53:0] t_pr2;
    typedef logic signed [39:0] t_vec;
    typedef logic        [39:0] t_mag40;
    typedef logic        [29:0] t_mag;
    typedef logic        [59:0] t_sq;
    typedef logic        [61:0] t_lsq;
    typedef logic        [30:0] t_root;
    typedef logic signed [31:0] t_unit;
    typedef logic signed [61:0] t_dotp;
    typedef logic signed [63:0] t_dot;
    typedef logic signed [33:0] t_cxy;
    typedef logic signed [23:0] t_cz;
    typedef logic [TOL_SHIFT:0]     t_tol;
    typedef logic [2*TOL_SHIFT+1:0] t_tolp;

    localparam t_cz         HALF_PI_Q20 = 24'sd1647099;
    localparam logic [15:0] ANGLE_MAX   = 16'd51472;

    localparam logic [19:0] ATAN_Q20 [CORDIC_STEPS] = '{
        20'd823550, 20'd486170, 20'd256879, 20'd130396, 20'd65451,
        20'd32757,  20'd16383,  20'd8192,   20'd4096,   20'd2048,
        20'd1024,   20'd512,    20'd256,    20'd128,    20'd64,
        20'd32,     20'd16,     20'd8,      20'd4,      20'd2
    };

    typedef struct packed {
        logic [61:0] rad;
        logic [34:0] rem;
        logic [30:0] root;
    } t_sqrt;

    typedef struct packed {
        logic [30:0] rem;
        logic [30:0] quo;
    } t_div;

    typedef struct packed {
        logic [33:0] x;
        logic [33:0] y;
        logic [23:0] z;
    } t_cordic;

    // one result bit of the digit-by-digit square root
    function automatic t_sqrt sqrt_step(t_sqrt s);
        logic [34:0] r2;
        logic [34:0] tr;
        t_sqrt       o;
        r2    = {s.rem[32:0], s.rad[61:60]};
        tr    = {2'b00, s.root, 2'b01};
        o.rad = {s.rad[59:0], 2'b00};
        if (r2 >= tr) begin
            o.rem  = r2 - tr;
            o.root = {s.root[29:0], 1'b1};
        end else begin
            o.rem  = r2;
            o.root = {s.root[29:0], 1'b0};
        end
        return o;
    endfunction

    // one quotient bit of the restoring divider
    function automatic t_div div_step(t_div s, t_root d, logic din);
        logic [31:0] r2;
        t_div        o;
        r2 = {s.rem, din};
        if (r2 >= {1'b0, d}) begin
            o.rem = 31'(r2 - {1'b0, d});
            o.quo = {s.quo[29:0], 1'b1};
        end else begin
            o.rem = r2[30:0];
            o.quo = {s.quo[29:0], 1'b0};
        end
        return o;
    endfunction

    // one vectoring rotation
    function automatic t_cordic cordic_step(t_cordic s, logic [4:0] idx);
        t_cxy    x;
        t_cxy    y;
        t_cxy    dx;
        t_cxy    dy;
        t_cz     z;
        t_cz     at;
        t_cordic o;
        x  = $signed(s.x);
        y  = $signed(s.y);
        z  = $signed(s.z);
        dx = y >>> idx;
        dy = x >>> idx;
        at = t_cz'(ATAN_Q20[idx]);
        if (y > 34'sd0) begin
            x = x + dx;
            y = y - dy;
            z = z + at;
        end else begin
            x = x - dx;
            y = y + dy;
            z = z - at;
        end
        o.x = x;
        o.y = y;
        o.z = z;
        return o;
    endfunction

endpackage

>>> rtl/vector_deflection_angle.sv
// ----------------------------------------------------------------------------
// vector_deflection_angle
// Angle between the undisplaced and displaced node vectors about an origin.
// ----------------------------------------------------------------------------
// One transaction enters per cycle while the output is not stalled. The two
// square root units and the divider resolve one result bit per stage (31
// stages each), and the arctangent rotator has 20 stages. The whole pipeline
// holds while a result waits at a stalled output. No memories, no clearing
// pass.
module vector_deflection_angle (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_node_x,
    input  logic signed [31:0] i_node_y,
    input  logic signed [31:0] i_node_z,
    input  logic signed [31:0] i_disp_x,
    input  logic signed [31:0] i_disp_y,
    input  logic signed [31:0] i_disp_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic        [15:0] o_angle,
    output logic               o_degenerate,
    input  logic               i_cfg_we,
    input  logic         [2:0] i_cfg_idx,
    input  logic        [31:0] i_cfg_data
);

    localparam int ST_SQ1 = 11;
    localparam int ST_DIV = ST_SQ1 + vda_pkg::SQRT_STEPS;
    localparam int ST_U   = ST_DIV + vda_pkg::DIV_STEPS;
    localparam int ST_PR  = ST_U + 1;
    localparam int ST_C   = ST_PR + 1;
    localparam int ST_R2  = ST_C + 1;
    localparam int ST_SQ2 = ST_R2 + 1;
    localparam int ST_CI  = ST_SQ2 + vda_pkg::SQRT_STEPS;
    localparam int ST_CR  = ST_CI + 1;
    localparam int ST_OUT = ST_CR + vda_pkg::CORDIC_STEPS;

    // configuration
    logic signed [31:0] r_org [3];
    logic               r_use_axis;
    logic signed [15:0] r_axis [3];
    logic        [1:0]  r_dcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0]   <= '0;
            r_org[1]   <= '0;
            r_org[2]   <= '0;
            r_use_axis <= 1'b0;
            r_axis[0]  <= '0;
            r_axis[1]  <= '0;
            r_axis[2]  <= 16'sd16384;
            r_dcnt     <= 2'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vda_pkg::REG_ORIGIN_X:   r_org[0]   <= i_cfg_data;
                vda_pkg::REG_ORIGIN_Y:   r_org[1]   <= i_cfg_data;
                vda_pkg::REG_ORIGIN_Z:   r_org[2]   <= i_cfg_data;
                vda_pkg::REG_USE_AXIS:   r_use_axis <= i_cfg_data[0];
                vda_pkg::REG_AXIS_X:     r_axis[0]  <= i_cfg_data[15:0];
                vda_pkg::REG_AXIS_Y:     r_axis[1]  <= i_cfg_data[15:0];
                vda_pkg::REG_AXIS_Z:     r_axis[2]  <= i_cfg_data[15:0];
                vda_pkg::REG_DISP_COUNT: r_dcnt     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic              w_en;
    logic [ST_OUT:1]   r_vld;

    assign w_en    = !r_vld[ST_OUT] || !i_stall;
    assign o_stall = !w_en;
    assign o_valid = r_vld[ST_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[ST_OUT-1:1], i_valid};
        end
    end

    // stage registers, index 0 is the undisplaced vector, 1 the displaced one
    vda_pkg::t_v1    r_v1 [2][3];
    vda_pkg::t_v1    r_v2 [2][3];
    vda_pkg::t_v1    r_v3 [2][3];
    vda_pkg::t_v1    r_v4 [2][3];
    vda_pkg::t_pr1   r_p2 [2][3];
    vda_pkg::t_pj    r_pj3 [2];
    vda_pkg::t_pr2   r_q4 [2][3];
    vda_pkg::t_vec   r_v5 [2][3];
    vda_pkg::t_mag40 r_m6 [2][3];
    logic            r_sg6 [2][3];
    vda_pkg::t_mag40 r_or6 [2];
    vda_pkg::t_mag   r_m7 [2][3];
    logic            r_sg7 [2][3];
    logic            r_big7 [2];
    vda_pkg::t_sq    r_sq8 [2][3];
    vda_pkg::t_mag   r_nm8 [2][3];
    logic            r_sg8 [2][3];
    logic            r_big8 [2];
    vda_pkg::t_lsq   r_la9 [2];
    vda_pkg::t_sq    r_nsq9 [2][3];
    vda_pkg::t_mag   r_nm9 [2][3];
    logic            r_sg9 [2][3];
    logic            r_big9 [2];
    vda_pkg::t_tol   r_lo10 [2];
    logic            r_small10 [2];
    logic            r_zero10 [2];
    vda_pkg::t_lsq   r_nl10 [2];
    vda_pkg::t_mag   r_nm10 [2][3];
    logic            r_sg10 [2][3];
    logic            r_big10 [2];

    vda_pkg::t_sqrt  r_sq1 [ST_SQ1:ST_DIV-1][2];
    vda_pkg::t_mag   r_nml [ST_SQ1:ST_DIV-1][2][3];
    logic            r_sgl [ST_SQ1:ST_DIV-1][2][3];
    vda_pkg::t_div   r_dv  [ST_DIV:ST_U-1][2][3];
    vda_pkg::t_root  r_dl  [ST_DIV:ST_U-1][2];
    logic            r_sgd [ST_DIV:ST_U-1][2][3];
    logic            r_dgl [ST_SQ1:ST_OUT-1];

    vda_pkg::t_unit  r_u [2][3];
    vda_pkg::t_dotp  r_pr [3];
    vda_pkg::t_unit  r_c;
    vda_pkg::t_lsq   r_rad2;
    vda_pkg::t_unit  r_cl [ST_R2:ST_CI-1];
    vda_pkg::t_sqrt  r_sq2 [ST_SQ2:ST_CI-1];
    vda_pkg::t_cordic r_ci;
    vda_pkg::t_cordic r_cr [ST_CR:ST_OUT-1];
    logic [15:0]     r_angle;
    logic            r_degen;

    // combinational stage logic
    logic signed [31:0] w_node [3];
    logic signed [31:0] w_disp [3];
    logic signed [15:0] w_ax [3];
    vda_pkg::t_v1       w_a1 [3];
    vda_pkg::t_v1       w_d1 [3];
    vda_pkg::t_pj       w_pj [2];
    vda_pkg::t_vec      w_v5 [2][3];
    vda_pkg::t_mag40    w_m6 [2][3];
    vda_pkg::t_mag      w_m7 [2][3];
    vda_pkg::t_mag      w_nm8 [2][3];
    logic               w_deg;
    vda_pkg::t_unit     w_c;
    vda_pkg::t_root     w_mc;
    vda_pkg::t_cordic   w_ci;
    logic [15:0]        w_ang;

    assign w_node[0] = i_node_x;
    assign w_node[1] = i_node_y;
    assign w_node[2] = i_node_z;
    assign w_disp[0] = i_disp_x;
    assign w_disp[1] = i_disp_y;
    assign w_disp[2] = i_disp_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ax[i] = (i < vda_pkg::DIMENSIONS) ? r_axis[i] : 16'sd0;
            w_a1[i] = (i < vda_pkg::DIMENSIONS)
                    ? vda_pkg::t_v1'(w_node[i]) - vda_pkg::t_v1'(r_org[i]) : '0;
            w_d1[i] = (i < vda_pkg::DIMENSIONS && i < int'(r_dcnt))
                    ? vda_pkg::t_v1'(w_disp[i]) : '0;
        end
    end

    // rounded projection of each vector onto the axis
    always_comb begin
        vda_pkg::t_sum1 s;
        for (int j = 0; j < 2; j++) begin
            s = vda_pkg::t_sum1'(r_p2[j][0]) + vda_pkg::t_sum1'(r_p2[j][1])
              + vda_pkg::t_sum1'(r_p2[j][2]) + 52'sd8192;
            w_pj[j] = vda_pkg::t_pj'(s >>> 14);
        end
    end

    always_comb begin
        vda_pkg::t_pr2 q;
        for (int j = 0; j < 2; j++) begin
            for (int i = 0; i < 3; i++) begin
                q = (r_q4[j][i] + 54'sd8192) >>> 14;
                w_v5[j][i] = r_use_axis
                           ? vda_pkg::t_vec'(r_v4[j][i]) - vda_pkg::t_vec'(q)
                           : vda_pkg::t_vec'(r_v4[j][i]);
                w_m6[j][i] = vda_pkg::t_mag40'(r_v5[j][i][39] ? -r_v5[j][i] : r_v5[j][i]);
            end
        end
    end

    // shrink below 2^30, truncating magnitudes
    logic [3:0] w_shr [2];
    always_comb begin
        int msb;
        for (int j = 0; j < 2; j++) begin
            msb = 0;
            for (int k = 0; k < 40; k++) begin
                if (r_or6[j][k]) begin
                    msb = k;
                end
            end
            w_shr[j] = (msb > 29) ? 4'(msb - 29) : 4'd0;
            for (int i = 0; i < 3; i++) begin
                w_m7[j][i] = vda_pkg::t_mag'(r_m6[j][i] >> w_shr[j]);
            end
        end
    end

    // normalize so the largest magnitude lies in [2^29, 2^30)
    always_comb begin
        int            msb;
        vda_pkg::t_mag o;
        logic [4:0]    l;
        for (int j = 0; j < 2; j++) begin
            o   = r_m7[j][0] | r_m7[j][1] | r_m7[j][2];
            msb = 0;
            for (int k = 0; k < 30; k++) begin
                if (o[k]) begin
                    msb = k;
                end
            end
            l = 5'(29 - msb);
            for (int i = 0; i < 3; i++) begin
                w_nm8[j][i] = r_m7[j][i] << l;
            end
        end
    end

    always_comb begin
        vda_pkg::t_tolp p;
        p     = vda_pkg::t_tolp'(r_lo10[0]) * vda_pkg::t_tolp'(r_lo10[1]);
        w_deg = r_zero10[0] || r_zero10[1]
             || (!r_big10[0] && !r_big10[1] && r_small10[0] && r_small10[1]
                 && p <= (vda_pkg::t_tolp'(1) << vda_pkg::TOL_SHIFT));
    end

    // rounded, clamped cosine
    always_comb begin
        vda_pkg::t_dot s;
        s = vda_pkg::t_dot'(r_pr[0]) + vda_pkg::t_dot'(r_pr[1])
          + vda_pkg::t_dot'(r_pr[2]) + 64'sd536870912;
        s = s >>> 30;
        if (s > 64'sd1073741824) begin
            w_c = 32'sd1073741824;
        end else if (s < -64'sd1073741824) begin
            w_c = -32'sd1073741824;
        end else begin
            w_c = vda_pkg::t_unit'(s);
        end
        // magnitude reaches 2^30 for parallel vectors
        w_mc = vda_pkg::t_root'(r_c[31] ? -r_c : r_c);
    end

    always_comb begin
        vda_pkg::t_unit c;
        vda_pkg::t_root s;
        c = r_cl[ST_CI-1];
        s = r_sq2[ST_CI-1].root;
        if (c < 32'sd0) begin
            w_ci.x = vda_pkg::t_cxy'(s);
            w_ci.y = -vda_pkg::t_cxy'(c);
            w_ci.z = vda_pkg::HALF_PI_Q20;
        end else begin
            w_ci.x = vda_pkg::t_cxy'(c);
            w_ci.y = vda_pkg::t_cxy'(s);
            w_ci.z = '0;
        end
    end

    always_comb begin
        vda_pkg::t_cz z;
        z = ($signed(r_cr[ST_OUT-1].z) + 24'sd32) >>> 6;
        if (z < 24'sd0) begin
            w_ang = '0;
        end else if (z > $signed({8'd0, vda_pkg::ANGLE_MAX})) begin
            w_ang = vda_pkg::ANGLE_MAX;
        end else begin
            w_ang = z[15:0];
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_v1[0][i] <= w_a1[i];
                r_v1[1][i] <= w_a1[i] + w_d1[i];
            end
            for (int j = 0; j < 2; j++) begin
                r_or6[j] <= w_m6[j][0] | w_m6[j][1] | w_m6[j][2];
                r_big7[j]  <= (w_shr[j] != 4'd0);
                r_big8[j]  <= r_big7[j];
                r_big9[j]  <= r_big8[j];
                r_big10[j] <= r_big9[j];
                r_pj3[j]   <= w_pj[j];
                r_la9[j]   <= vda_pkg::t_lsq'(r_sq8[j][0]) + vda_pkg::t_lsq'(r_sq8[j][1])
                            + vda_pkg::t_lsq'(r_sq8[j][2]);
                r_lo10[j]    <= r_la9[j][vda_pkg::TOL_SHIFT:0];
                r_small10[j] <= r_la9[j] <= (vda_pkg::t_lsq'(1) << vda_pkg::TOL_SHIFT);
                r_zero10[j]  <= (r_la9[j] == '0);
                r_nl10[j]  <= vda_pkg::t_lsq'(r_nsq9[j][0]) + vda_pkg::t_lsq'(r_nsq9[j][1])
                            + vda_pkg::t_lsq'(r_nsq9[j][2]);
                r_sq1[ST_SQ1][j] <= vda_pkg::sqrt_step('{rad: r_nl10[j], rem: '0, root: '0});
                for (int i = 0; i < 3; i++) begin
                    r_p2[j][i]  <= vda_pkg::t_pr1'(w_ax[i]) * vda_pkg::t_pr1'(r_v1[j][i]);
                    r_v2[j][i]  <= r_v1[j][i];
                    r_v3[j][i]  <= r_v2[j][i];
                    r_v4[j][i]  <= r_v3[j][i];
                    r_q4[j][i]  <= vda_pkg::t_pr2'(w_ax[i]) * vda_pkg::t_pr2'(r_pj3[j]);
                    r_v5[j][i]  <= w_v5[j][i];
                    r_m6[j][i]  <= w_m6[j][i];
                    r_sg6[j][i] <= r_v5[j][i][39];
                    r_m7[j][i]  <= w_m7[j][i];
                    r_sg7[j][i] <= r_sg6[j][i];
                    r_sq8[j][i] <= vda_pkg::t_sq'(r_m7[j][i]) * vda_pkg::t_sq'(r_m7[j][i]);
                    r_nm8[j][i] <= w_nm8[j][i];
                    r_sg8[j][i] <= r_sg7[j][i];
                    r_nsq9[j][i] <= vda_pkg::t_sq'(r_nm8[j][i]) * vda_pkg::t_sq'(r_nm8[j][i]);
                    r_nm9[j][i]  <= r_nm8[j][i];
                    r_sg9[j][i]  <= r_sg8[j][i];
                    r_nm10[j][i] <= r_nm9[j][i];
                    r_sg10[j][i] <= r_sg9[j][i];
                    r_nml[ST_SQ1][j][i] <= r_nm10[j][i];
                    r_sgl[ST_SQ1][j][i] <= r_sg10[j][i];
                    // first divider step takes the low dividend bit
                    r_dv[ST_DIV][j][i] <= vda_pkg::div_step(
                        '{rem: 31'(r_nml[ST_DIV-1][j][i] >> 1), quo: '0},
                        r_sq1[ST_DIV-1][j].root, r_nml[ST_DIV-1][j][i][0]);
                    r_sgd[ST_DIV][j][i] <= r_sgl[ST_DIV-1][j][i];
                    r_u[j][i] <= r_sgd[ST_U-1][j][i]
                               ? -vda_pkg::t_unit'(r_dv[ST_U-1][j][i].quo)
                               : vda_pkg::t_unit'(r_dv[ST_U-1][j][i].quo);
                end
                r_dl[ST_DIV][j] <= r_sq1[ST_DIV-1][j].root;
                for (int k = ST_SQ1 + 1; k < ST_DIV; k++) begin
                    r_sq1[k][j] <= vda_pkg::sqrt_step(r_sq1[k-1][j]);
                    for (int i = 0; i < 3; i++) begin
                        r_nml[k][j][i] <= r_nml[k-1][j][i];
                        r_sgl[k][j][i] <= r_sgl[k-1][j][i];
                    end
                end
                for (int k = ST_DIV + 1; k < ST_U; k++) begin
                    r_dl[k][j] <= r_dl[k-1][j];
                    for (int i = 0; i < 3; i++) begin
                        r_dv[k][j][i]  <= vda_pkg::div_step(r_dv[k-1][j][i],
                                                            r_dl[k-1][j], 1'b0);
                        r_sgd[k][j][i] <= r_sgd[k-1][j][i];
                    end
                end
            end

            r_dgl[ST_SQ1] <= w_deg;
            for (int k = ST_SQ1 + 1; k < ST_OUT; k++) begin
                r_dgl[k] <= r_dgl[k-1];
            end

            for (int i = 0; i < 3; i++) begin
                r_pr[i] <= vda_pkg::t_dotp'(r_u[0][i]) * vda_pkg::t_dotp'(r_u[1][i]);
            end
            r_c    <= w_c;
            r_rad2 <= (vda_pkg::t_lsq'(1) << 60)
                    - vda_pkg::t_lsq'(vda_pkg::t_lsq'(w_mc) * vda_pkg::t_lsq'(w_mc));
            r_cl[ST_R2] <= r_c;
            for (int k = ST_R2 + 1; k < ST_CI; k++) begin
                r_cl[k] <= r_cl[k-1];
            end
            r_sq2[ST_SQ2] <= vda_pkg::sqrt_step('{rad: r_rad2, rem: '0, root: '0});
            for (int k = ST_SQ2 + 1; k < ST_CI; k++) begin
                r_sq2[k] <= vda_pkg::sqrt_step(r_sq2[k-1]);
            end
            r_ci <= w_ci;
            r_cr[ST_CR] <= vda_pkg::cordic_step(r_ci, 5'd0);
            for (int k = ST_CR + 1; k < ST_OUT; k++) begin
                r_cr[k] <= vda_pkg::cordic_step(r_cr[k-1], 5'(k - ST_CR));
            end
            r_angle <= r_dgl[ST_OUT-1] ? 16'd0 : w_ang;
            r_degen <= r_dgl[ST_OUT-1];
        end
    end

    assign o_angle      = r_angle;
    assign o_degenerate = r_degen;

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_angle == 16'd0)
        else $error("degenerate result with nonzero angle");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_angle <= vda_pkg::ANGLE_MAX)
        else $error("angle above pi");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output backpressure");

endmodule

>>> tb/sv/vector_deflection_angle_test.sv
// ----------------------------------------------------------------------------
// vector_deflection_angle_test
// Streams node/displacement transactions through the deflection angle block
// in several register settings; checks each angle and degenerate flag against
// a typed value or an in-bench fixed-point predictor of the same arithmetic.
// ----------------------------------------------------------------------------
module vector_deflection_angle_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] angle;
        logic        degenerate;
    } t_angle_res;

    typedef struct packed {
        logic [31:0] nx, ny, nz, dx, dy, dz;
        logic        typed;
        logic [15:0] angle;
        logic        degenerate;
    } t_node_row;

    localparam int NUM_DIRECTED = 14;
    localparam int RAND_PER_PHASE = 225;
    localparam int DRAIN_CYCLES = 160;
    localparam logic [31:0] MAXC = 32'h7fff_ffff;
    localparam logic [31:0] MINC = 32'h8000_0000;

    // typed expectations only for the obvious degenerate rows
    localparam t_node_row DIRECTED_NODES [NUM_DIRECTED] = '{
        '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 16'd0, 1'b1},
        '{32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 16'd0, 1'b1},
        '{32'h10000, 32'd0, 32'd0, -32'sh10000, 32'd0, 32'd0, 1'b1, 16'd0, 1'b1},
        '{32'h10000, 32'd0, 32'd0, 32'd0, 32'h10000, 32'd0, 1'b0, 16'd0, 1'b0},
        '{32'h10000, 32'd0, 32'd0, -32'sh20000, 32'd0, 32'd0, 1'b0, 16'd0, 1'b0},
        '{MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, 1'b0, 16'd0, 1'b0},
        '{MINC, MINC, MINC, MINC, MINC, MINC, 1'b0, 16'd0, 1'b0},
        '{MAXC, MAXC, MAXC, MINC, MINC, MINC, 1'b0, 16'd0, 1'b0},
        '{MINC, MINC, MINC, MAXC, MAXC, MAXC, 1'b0, 16'd0, 1'b0},
        '{32'd0, MAXC, 32'd0, MAXC, 32'd0, MINC, 1'b0, 16'd0, 1'b0},
        '{32'h1000, 32'h1000, 32'h1000, 32'd0, 32'd0, 32'd0, 1'b0, 16'd0, 1'b0},
        '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'd2, 32'd2, 32'd2,
          1'b1, 16'd0, 1'b1},
        '{32'h4000_0000, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 1'b0, 16'd0, 1'b0},
        '{32'd0, 32'd0, 32'h10000, 32'd0, 32'd0, 32'h10000, 1'b0, 16'd0, 1'b0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_node_x, i_node_y, i_node_z;
    logic signed [31:0] i_disp_x, i_disp_y, i_disp_z;
    logic               o_valid;
    logic               i_stall;
    logic        [15:0] o_angle;
    logic               o_degenerate;
    logic               i_cfg_we;
    logic         [2:0] i_cfg_idx;
    logic        [31:0] i_cfg_data;

    // shadow copy of the block registers
    logic signed [31:0] origin_q [3];
    logic               use_axis_q;
    logic signed [15:0] axis_q [3];
    logic         [1:0] disp_count_q;

    t_angle_res expected_angles [$];
    int         mismatch_cnt;
    int         sent_cnt;
    int         result_cnt;
    int         degen_cnt;
    int         idle_pct;
    int         hold_left;

    vector_deflection_angle dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_node_x    (i_node_x),
        .i_node_y    (i_node_y),
        .i_node_z    (i_node_z),
        .i_disp_x    (i_disp_x),
        .i_disp_y    (i_disp_y),
        .i_disp_z    (i_disp_z),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_angle     (o_angle),
        .o_degenerate(o_degenerate),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic longint mag(longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic logic [63:0] isqrt(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint max_mag(longint v [3]);
        longint m;
        m = mag(v[0]);
        if (mag(v[1]) > m) m = mag(v[1]);
        if (mag(v[2]) > m) m = mag(v[2]);
        return m;
    endfunction

    function automatic logic [63:0] sq_len(longint v [3]);
        return 64'(v[0] * v[0]) + 64'(v[1] * v[1]) + 64'(v[2] * v[2]);
    endfunction

    function automatic void project_plane(inout longint v [3], input longint ax [3]);
        longint p;
        p = (ax[0] * v[0] + ax[1] * v[1] + ax[2] * v[2] + 8192) >>> 14;
        for (int i = 0; i < 3; i++) v[i] = v[i] - ((ax[i] * p + 8192) >>> 14);
    endfunction

    // truncating shift until every component is below 2^30
    function automatic int shrink_vec(inout longint v [3]);
        longint m;
        int     s;
        m = max_mag(v);
        s = 0;
        while ((m >>> s) >= (longint'(1) <<< 30)) s++;
        for (int i = 0; i < 3; i++) v[i] = (v[i] < 0) ? -((-v[i]) >>> s) : (v[i] >>> s);
        return s;
    endfunction

    function automatic void unit_vec(input longint v_in [3], output longint u [3]);
        longint      v [3];
        logic [63:0] len;
        v = v_in;
        while (max_mag(v) < (longint'(1) <<< 29))
            for (int i = 0; i < 3; i++) v[i] = v[i] * 2;
        len = isqrt(sq_len(v));
        for (int i = 0; i < 3; i++) u[i] = (v[i] * (longint'(1) <<< 30)) / longint'(len);
    endfunction

    function automatic t_angle_res predict_deflection(t_node_row it);
        longint      nd [3];
        longint      ds [3];
        longint      a [3];
        longint      b [3];
        longint      ax [3];
        longint      ua [3];
        longint      ub [3];
        longint      c, x, y, z, t, dxv, dyv, r;
        logic [63:0] la, lb, s;
        int          sa, sb;
        t_angle_res  res;
        nd[0] = longint'($signed(it.nx));
        nd[1] = longint'($signed(it.ny));
        nd[2] = longint'($signed(it.nz));
        ds[0] = longint'($signed(it.dx));
        ds[1] = longint'($signed(it.dy));
        ds[2] = longint'($signed(it.dz));
        for (int i = 0; i < 3; i++) begin
            ax[i] = longint'(axis_q[i]);
            a[i]  = nd[i] - longint'(origin_q[i]);
            b[i]  = a[i] + ((i < int'(disp_count_q)) ? ds[i] : 0);
        end
        if (use_axis_q) begin
            project_plane(a, ax);
            project_plane(b, ax);
        end
        sa = shrink_vec(a);
        sb = shrink_vec(b);
        la = sq_len(a);
        lb = sq_len(b);
        res.angle = 16'd0;
        res.degenerate = 1'b1;
        if (la == 0 || lb == 0) return res;
        if (sa == 0 && sb == 0 && la <= (64'd1 << vda_pkg::TOL_SHIFT) / lb) return res;
        res.degenerate = 1'b0;
        unit_vec(a, ua);
        unit_vec(b, ub);
        c = (ua[0] * ub[0] + ua[1] * ub[1] + ua[2] * ub[2] + (longint'(1) <<< 29)) >>> 30;
        if (c > (longint'(1) <<< 30)) c = longint'(1) <<< 30;
        if (c < -(longint'(1) <<< 30)) c = -(longint'(1) <<< 30);
        s = isqrt((64'd1 << 60) - 64'(mag(c) * mag(c)));
        x = c;
        y = longint'(s);
        z = 0;
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = longint'(vda_pkg::HALF_PI_Q20);
        end
        for (int i = 0; i < vda_pkg::CORDIC_STEPS; i++) begin
            dxv = y >>> i;
            dyv = x >>> i;
            if (y > 0) begin
                x = x + dxv;
                y = y - dyv;
                z = z + longint'(vda_pkg::ATAN_Q20[i]);
            end else begin
                x = x - dxv;
                y = y + dyv;
                z = z - longint'(vda_pkg::ATAN_Q20[i]);
            end
        end
        r = (z + 32) >>> 6;
        if (r < 0) r = 0;
        if (r > longint'(vda_pkg::ANGLE_MAX)) r = longint'(vda_pkg::ANGLE_MAX);
        res.angle = r[15:0];
        return res;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        $display("mismatch on %s of result %0d: got %0d, expected %0d",
                 what, result_cnt, got, want);
        mismatch_cnt++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_angle_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_angles.size() == 0) begin
                flag_mismatch("unexpected transaction", int'(o_angle), -1);
            end else begin
                want = expected_angles.pop_front();
                if (o_angle !== want.angle)
                    flag_mismatch("angle", int'(o_angle), int'(want.angle));
                if (o_degenerate !== want.degenerate)
                    flag_mismatch("degenerate", int'(o_degenerate), int'(want.degenerate));
                if (want.degenerate) degen_cnt++;
            end
            result_cnt++;
        end
    end

    // receiver stall, with a long counted hold when asked
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    task automatic write_reg(vda_pkg::t_reg_idx idx, logic [31:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            vda_pkg::REG_ORIGIN_X:   origin_q[0] = data;
            vda_pkg::REG_ORIGIN_Y:   origin_q[1] = data;
            vda_pkg::REG_ORIGIN_Z:   origin_q[2] = data;
            vda_pkg::REG_USE_AXIS:   use_axis_q = data[0];
            vda_pkg::REG_AXIS_X:     axis_q[0] = data[15:0];
            vda_pkg::REG_AXIS_Y:     axis_q[1] = data[15:0];
            vda_pkg::REG_AXIS_Z:     axis_q[2] = data[15:0];
            vda_pkg::REG_DISP_COUNT: disp_count_q = data[1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                              logic ua, logic [15:0] axx, logic [15:0] axy,
                              logic [15:0] axz, logic [1:0] cnt);
        write_reg(vda_pkg::REG_ORIGIN_X, ox);
        write_reg(vda_pkg::REG_ORIGIN_Y, oy);
        write_reg(vda_pkg::REG_ORIGIN_Z, oz);
        write_reg(vda_pkg::REG_USE_AXIS, {31'd0, ua});
        write_reg(vda_pkg::REG_AXIS_X, {{16{axx[15]}}, axx});
        write_reg(vda_pkg::REG_AXIS_Y, {{16{axy[15]}}, axy});
        write_reg(vda_pkg::REG_AXIS_Z, {{16{axz[15]}}, axz});
        write_reg(vda_pkg::REG_DISP_COUNT, {30'd0, cnt});
    endtask

    task automatic wait_drained();
        wait (expected_angles.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_node(t_node_row it);
        while ($urandom_range(99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid  = 1'b1;
        i_node_x = it.nx;
        i_node_y = it.ny;
        i_node_z = it.nz;
        i_disp_x = it.dx;
        i_disp_y = it.dy;
        i_disp_z = it.dz;
        do @(posedge i_clk); while (o_stall);
        if (it.typed) expected_angles.push_back('{it.angle, it.degenerate});
        else expected_angles.push_back(predict_deflection(it));
        sent_cnt++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord(int shape);
        case (shape)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000);
            2: return 32'($signed($urandom_range(0, 600)) - 300);
            default: begin
                case ($urandom_range(4))
                    0: return MAXC;
                    1: return MINC;
                    2: return 32'hffff_ffff;
                    3: return 32'd1;
                    default: return 32'd0;
                endcase
            end
        endcase
    endfunction

    function automatic t_node_row rand_node();
        t_node_row it;
        int        pick;
        int        shape;
        pick = $urandom_range(99);
        shape = (pick < 40) ? 0 : (pick < 70) ? 1 : (pick < 85) ? 2 : 3;
        it = '0;
        it.nx = rand_coord(shape);
        it.ny = rand_coord(shape);
        it.nz = rand_coord(shape);
        it.dx = rand_coord($urandom_range(3));
        it.dy = rand_coord($urandom_range(3));
        it.dz = rand_coord($urandom_range(3));
        if (pick >= 95) begin
            // either along z only, or a displacement cancelling the node
            if (pick[0]) begin
                it.nx = 0; it.ny = 0; it.dx = 0; it.dy = 0;
            end else begin
                it.dx = -it.nx; it.dy = -it.ny; it.dz = -it.nz;
            end
        end
        return it;
    endfunction

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++) send_node(rand_node());
        i_valid = 1'b0;
        wait_drained();
    endtask

    initial begin
        #5ms;
        $display("timeout waiting for results");
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_node_x = '0; i_node_y = '0; i_node_z = '0;
        i_disp_x = '0; i_disp_y = '0; i_disp_z = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = vda_pkg::REG_ORIGIN_X;
        i_cfg_data = '0;
        origin_q = '{32'sd0, 32'sd0, 32'sd0};
        use_axis_q = 1'b0;
        axis_q = '{16'sd0, 16'sd0, 16'sd16384};
        disp_count_q = 2'd3;
        mismatch_cnt = 0;
        sent_cnt = 0;
        result_cnt = 0;
        degen_cnt = 0;
        idle_pct = 34;
        hold_left = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int n = 0; n < NUM_DIRECTED; n++) send_node(DIRECTED_NODES[n]);
        i_valid = 1'b0;
        wait_drained();

        set_config(MAXC, MINC, 32'h1234_5678, 1'b0, 16'd0, 16'd0, 16'd16384, 2'd1);
        random_phase(RAND_PER_PHASE);
        set_config(32'd0, 32'd0, 32'd0, 1'b1, 16'd0, 16'd0, 16'd16384, 2'd3);
        random_phase(RAND_PER_PHASE);
        set_config(MINC, 32'd0, MAXC, 1'b1, 16'd16384, -16'sd16384, 16'd0, 2'd2);
        random_phase(RAND_PER_PHASE);
        set_config($urandom, $urandom, $urandom, 1'b1,
                   16'($signed($urandom_range(0, 32768)) - 16384),
                   16'($signed($urandom_range(0, 32768)) - 16384),
                   16'($signed($urandom_range(0, 32768)) - 16384), 2'd0);
        random_phase(RAND_PER_PHASE);

        // no idling at all, and a long output hold that backs up the pipeline
        set_config(32'd0, 32'd0, 32'd0, 1'b0, 16'd0, 16'd0, 16'd16384, 2'd3);
        idle_pct = 0;
        hold_left = 400;
        random_phase(RAND_PER_PHASE);
        idle_pct = 34;

        set_config(rand_coord(1), rand_coord(1), rand_coord(1), 1'b1,
                   16'd16384, 16'd16384, -16'sd16384, 2'd3);
        random_phase(RAND_PER_PHASE);

        $display("sent %0d transactions over 7 register settings, %0d results checked",
                 sent_cnt, result_cnt);
        $display("%0d degenerate results seen, %0d mismatches", degen_cnt, mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
